// ===== sv/mfdr_pkg.sv =====
// ----------------------------------------------------------------------------
// mfdr_pkg
// Shared types and constants for the mesh frame duplicate filter and router.
// ----------------------------------------------------------------------------
package mfdr_pkg;

  localparam int KEY_W    = 32;
  localparam int CFG_IDX_W = 4;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_RELAY_ENABLE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_NODE     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_MAGIC  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAG_MASK    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELAY_MASK   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_CLASS   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TELEM_CLASS  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VIDEO_CLASS  = 4'd7;

  localparam logic [7:0]  BROADCAST_NODE = 8'hFF;
  localparam logic [7:0]  NO_FRAG_KEY    = 8'hFF;
  localparam logic [15:0] CTRL_CNT_MAX   = 16'hFFFF;

  localparam logic [1:0] PRIO_CTRL  = 2'd0;
  localparam logic [1:0] PRIO_TELEM = 2'd1;
  localparam logic [1:0] PRIO_VIDEO = 2'd2;
  localparam logic [1:0] PRIO_BULK  = 2'd3;

  // search token walking along the key chain
  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic             hit;
  } probe_t;

  typedef struct packed {
    logic        frag_present;
    logic [7:0]  frag_byte;
    logic [7:0]  hop_ttl;
    logic [15:0] frame_seq;
    logic [7:0]  class_code;
    logic [7:0]  flag_bits;
    logic [7:0]  dest_node;
    logic [7:0]  source_node;
    logic [7:0]  magic_byte;
    logic        header_complete;
  } hdr_t;

endpackage

// ===== sv/mfdr_cell.sv =====
// ----------------------------------------------------------------------------
// mfdr_cell
// One history cell: holds a key, shifts it on insert, and checks the probe
// token that passes through it on its way down the chain.
// ----------------------------------------------------------------------------
module mfdr_cell
  import mfdr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             shift_en,
  input  logic             occupied,
  input  logic [KEY_W-1:0] key_in,
  output logic [KEY_W-1:0] key_out,
  input  probe_t           probe_in,
  output probe_t           probe_out
);

  logic [KEY_W-1:0] key;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      key <= key_in;
    end
  end

  // hit only counts against a cell that has been filled
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.vld <= 1'b0;
    end else begin
      probe_out.vld <= probe_in.vld;
    end
    probe_out.key <= probe_in.key;
    probe_out.hit <= probe_in.hit | (occupied & (key == probe_in.key));
  end

  assign key_out = key;

endmodule

// ===== sv/mesh_frame_dedup_router.sv =====
// ----------------------------------------------------------------------------
// mesh_frame_dedup_router
// Mesh frame header filter: duplicate check against a chain of recent keys,
// relay/local decision, TTL and flag patch, priority and control counting.
// ----------------------------------------------------------------------------
// Slot command or invalid header: accept, finish state, result register.
// Valid header: launch register, then the probe word walks one key cell a
// cycle, then finish state and result register. One word at a time: the next
// word is taken once the current result is registered (held by back-pressure).
// Reset (rst, synchronous): history empty, control counter zero, registers
// at defaults (telemetry class 1, video class 2, all others 0).
module mesh_frame_dedup_router
  import mfdr_pkg::*;
#(
  parameter int WINDOW = 32
)(
  input  logic                 clk,
  input  logic                 rst,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  // input header stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // header_complete, magic_byte, source_node, dest_node, flag_bits,
  // class_code, frame_seq, hop_ttl, fragment_byte, fragment_present, pad
  input  logic [79:0]          s_tdata,
  // command
  input  logic                 s_tuser,
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // valid_frame, duplicate, to_local, relay, ttl_expired, next_ttl,
  // next_flags, priority_res, ctrl_count, pad
  output logic [39:0]          m_tdata
);

  localparam int FILL_W = $clog2(WINDOW + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  // configuration
  logic       relay_enable;
  logic [7:0] own_node;
  logic [7:0] frame_magic;
  logic [7:0] frag_mask;
  logic [7:0] relay_mask;
  logic [7:0] ctrl_class;
  logic [7:0] telem_class;
  logic [7:0] video_class;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      relay_enable <= 1'b0;
      own_node     <= 8'd0;
      frame_magic  <= 8'd0;
      frag_mask    <= 8'd0;
      relay_mask   <= 8'd0;
      ctrl_class   <= 8'd0;
      telem_class  <= 8'd1;
      video_class  <= 8'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RELAY_ENABLE: relay_enable <= cfg_data[0];
        REG_OWN_NODE:     own_node     <= cfg_data;
        REG_FRAME_MAGIC:  frame_magic  <= cfg_data;
        REG_FRAG_MASK:    frag_mask    <= cfg_data;
        REG_RELAY_MASK:   relay_mask   <= cfg_data;
        REG_CTRL_CLASS:   ctrl_class   <= cfg_data;
        REG_TELEM_CLASS:  telem_class  <= cfg_data;
        REG_VIDEO_CLASS:  video_class  <= cfg_data;
        default: ;
      endcase
    end
  end

  // incoming word decode
  hdr_t             in_hdr;
  logic             in_ok;
  logic [7:0]       in_fidx;
  logic [7:0]       in_fkey;
  logic [KEY_W-1:0] in_key;

  always_comb begin
    in_hdr  = hdr_t'(s_tdata[73:0]);
    in_ok   = in_hdr.header_complete && (in_hdr.magic_byte == frame_magic);
    in_fidx = in_hdr.frag_present ? in_hdr.frag_byte : 8'd0;
    in_fkey = ((in_hdr.flag_bits & frag_mask) != 8'd0) ? in_fidx : NO_FRAG_KEY;
    in_key  = {in_hdr.source_node, in_hdr.frame_seq, in_fkey};
  end

  // control
  logic [1:0]       state;
  logic [1:0]       state_next;
  hdr_t             hdr;
  logic             cmd;
  logic             hdr_ok;
  logic [KEY_W-1:0] item_key;
  logic             launch;
  logic             hit;
  logic [FILL_W-1:0] fill;
  logic [15:0]      ctrl_counter;

  logic in_acc;
  logic finish;
  logic insert;
  probe_t probe_chain [WINDOW+1];
  logic [KEY_W-1:0] key_chain [WINDOW+1];

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign finish   = (state == S_FINISH) && (!m_tvalid || m_tready);
  assign insert   = finish && !cmd && hdr_ok && !hit;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = (!s_tuser && in_ok) ? S_SEARCH : S_FINISH;
        end
      end
      S_SEARCH: begin
        if (probe_chain[WINDOW].vld) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      launch <= 1'b0;
      fill   <= '0;
    end else begin
      state  <= state_next;
      launch <= in_acc && !s_tuser && in_ok;
      if (insert && (fill != FILL_W'(WINDOW))) begin
        fill <= fill + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hdr      <= in_hdr;
      cmd      <= s_tuser;
      hdr_ok   <= in_ok;
      item_key <= in_key;
      hit      <= 1'b0;
    end else if ((state == S_SEARCH) && probe_chain[WINDOW].vld) begin
      hit <= probe_chain[WINDOW].hit;
    end
  end

  // key chain: cell 0 holds the newest key
  assign probe_chain[0] = '{vld: launch, key: item_key, hit: 1'b0};
  assign key_chain[0]   = item_key;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    mfdr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift_en  (insert),
      .occupied  (FILL_W'(i) < fill),
      .key_in    (key_chain[i]),
      .key_out   (key_chain[i+1]),
      .probe_in  (probe_chain[i]),
      .probe_out (probe_chain[i+1])
    );
  end

  // result
  logic        r_valid;
  logic        r_dup;
  logic        r_local;
  logic        r_relay;
  logic        r_expired;
  logic [7:0]  r_ttl;
  logic [7:0]  r_flags;
  logic [1:0]  r_prio;
  logic [15:0] ctrl_counter_next;
  logic        want_relay;

  always_comb begin
    r_valid           = 1'b0;
    r_dup             = 1'b0;
    r_local           = 1'b0;
    r_relay           = 1'b0;
    r_expired         = 1'b0;
    r_ttl             = 8'd0;
    r_flags           = 8'd0;
    r_prio            = PRIO_CTRL;
    want_relay        = 1'b0;
    ctrl_counter_next = ctrl_counter;
    if (cmd) begin
      ctrl_counter_next = 16'd0;
    end else if (!hdr_ok) begin
      r_local = 1'b1;
    end else begin
      r_valid = 1'b1;
      if (hdr.class_code == ctrl_class) begin
        r_prio = PRIO_CTRL;
      end else if (hdr.class_code == telem_class) begin
        r_prio = PRIO_TELEM;
      end else if (hdr.class_code == video_class) begin
        r_prio = PRIO_VIDEO;
      end else begin
        r_prio = PRIO_BULK;
      end
      if (hit) begin
        r_dup = 1'b1;
      end else begin
        r_local = 1'b1;
        if (relay_enable) begin
          if (hdr.dest_node == own_node) begin
            want_relay = 1'b0;
          end else if (hdr.dest_node == BROADCAST_NODE) begin
            want_relay = 1'b1;
          end else begin
            r_local    = 1'b0;
            want_relay = 1'b1;
          end
          if (hdr.source_node == own_node) begin
            want_relay = 1'b0;
          end
        end
        if ((hdr.class_code == ctrl_class) &&
            ((hdr.dest_node == own_node) || (hdr.dest_node == BROADCAST_NODE)) &&
            (ctrl_counter != CTRL_CNT_MAX)) begin
          ctrl_counter_next = ctrl_counter + 16'd1;
        end
        if (want_relay) begin
          if (hdr.hop_ttl <= 8'd1) begin
            r_expired = 1'b1;
          end else begin
            r_relay = 1'b1;
            r_ttl   = hdr.hop_ttl - 8'd1;
            r_flags = hdr.flag_bits | relay_mask;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid     <= 1'b0;
      ctrl_counter <= 16'd0;
    end else begin
      if (finish) begin
        m_tvalid     <= 1'b1;
        ctrl_counter <= ctrl_counter_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tdata <= {1'b0, ctrl_counter_next, r_prio, r_flags, r_ttl,
                  r_expired, r_relay, r_local, r_dup, r_valid};
    end
  end

endmodule

// ===== tb/tb_mesh_frame_dedup_router.sv =====
// ----------------------------------------------------------------------------
// tb_mesh_frame_dedup_router
// Self-checking bench for the mesh frame duplicate filter and router. A
// scoreboard class predicts each result word from the accepted header words
// and the register writes. Directed headers come first, then random phases
// that each use their own register setting and one of three idling patterns.
// ----------------------------------------------------------------------------
module tb_mesh_frame_dedup_router;
  import mfdr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW          = 32;
  localparam int RAND_PHASES     = 8;
  localparam int WORDS_PER_PHASE = 160;
  localparam int CYCLE_LIMIT     = 600000;

  localparam logic CMD_HEADER   = 1'b0;
  localparam logic CMD_NEW_SLOT = 1'b1;

  // result word, valid_frame in bit 0
  typedef struct packed {
    logic [15:0] ctrl_count;
    logic [1:0]  prio;
    logic [7:0]  next_flags;
    logic [7:0]  next_ttl;
    logic        ttl_expired;
    logic        relay;
    logic        to_local;
    logic        duplicate;
    logic        valid_frame;
  } verdict_t;

  class dedup_scoreboard;
    logic        relay_on;
    logic [7:0]  node_id;
    logic [7:0]  magic;
    logic [7:0]  frag_mask;
    logic [7:0]  relay_mask;
    logic [7:0]  ctrl_cls;
    logic [7:0]  telem_cls;
    logic [7:0]  video_cls;
    logic [31:0] recent_keys[$];   // newest at the back
    logic [15:0] ctrl_frames;
    verdict_t    pending[$];
    int          errors;

    function new();
      relay_on    = 1'b0;
      node_id     = '0;
      magic       = '0;
      frag_mask   = '0;
      relay_mask  = '0;
      ctrl_cls    = 8'd0;
      telem_cls   = 8'd1;
      video_cls   = 8'd2;
      ctrl_frames = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        REG_RELAY_ENABLE: relay_on   = val[0];
        REG_OWN_NODE:     node_id    = val;
        REG_FRAME_MAGIC:  magic      = val;
        REG_FRAG_MASK:    frag_mask  = val;
        REG_RELAY_MASK:   relay_mask = val;
        REG_CTRL_CLASS:   ctrl_cls   = val;
        REG_TELEM_CLASS:  telem_cls  = val;
        REG_VIDEO_CLASS:  video_cls  = val;
        default: ;
      endcase
    endfunction

    // first match wins when class codes overlap
    function logic [1:0] class_prio(logic [7:0] cls);
      if (cls == ctrl_cls)  return PRIO_CTRL;
      if (cls == telem_cls) return PRIO_TELEM;
      if (cls == video_cls) return PRIO_VIDEO;
      return PRIO_BULK;
    endfunction

    function void note_header(hdr_t h, logic cmd);
      verdict_t    v;
      logic [7:0]  fkey;
      logic [31:0] key;
      logic        hit;
      logic        want_relay;
      v = '0;
      if (cmd == CMD_NEW_SLOT) begin
        ctrl_frames = '0;
      end else if (!h.header_complete || h.magic_byte != magic) begin
        v.to_local = 1'b1;
      end else begin
        if ((h.flag_bits & frag_mask) != 8'h00)
          fkey = h.frag_present ? h.frag_byte : 8'h00;
        else
          fkey = NO_FRAG_KEY;
        key = {h.source_node, h.frame_seq, fkey};
        v.valid_frame = 1'b1;
        v.prio = class_prio(h.class_code);
        hit = 1'b0;
        foreach (recent_keys[i])
          if (recent_keys[i] == key) hit = 1'b1;
        if (hit) begin
          v.duplicate = 1'b1;
        end else begin
          recent_keys.push_back(key);
          if (recent_keys.size() > WINDOW) void'(recent_keys.pop_front());
          want_relay = 1'b0;
          v.to_local = 1'b1;
          if (relay_on) begin
            if (h.dest_node == node_id) begin
              want_relay = 1'b0;
            end else if (h.dest_node == BROADCAST_NODE) begin
              want_relay = 1'b1;
            end else begin
              v.to_local = 1'b0;
              want_relay = 1'b1;
            end
            if (h.source_node == node_id) want_relay = 1'b0;
          end
          if (h.class_code == ctrl_cls &&
              (h.dest_node == node_id || h.dest_node == BROADCAST_NODE) &&
              ctrl_frames != CTRL_CNT_MAX)
            ctrl_frames++;
          if (want_relay) begin
            if (h.hop_ttl <= 8'd1) begin
              v.ttl_expired = 1'b1;
            end else begin
              v.relay      = 1'b1;
              v.next_ttl   = h.hop_ttl - 8'd1;
              v.next_flags = h.flag_bits | relay_mask;
            end
          end
        end
      end
      // the counter is reported on every word, whatever its kind
      v.ctrl_count = ctrl_frames;
      pending.push_back(v);
    endfunction

    function void field_check(string what, longint want, longint got);
      if (want != got) begin
        errors++;
        $display("%0t %s: expected %0h actual %0h", $time, what, want, got);
      end
    endfunction

    function void check_result(logic [39:0] word);
      verdict_t got;
      verdict_t want;
      got = word[38:0];
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual %0h", $time, word);
        return;
      end
      want = pending.pop_front();
      field_check("valid_frame",   want.valid_frame,   got.valid_frame);
      field_check("duplicate",     want.duplicate,     got.duplicate);
      field_check("to_local",      want.to_local,      got.to_local);
      field_check("relay",         want.relay,         got.relay);
      field_check("ttl_expired",   want.ttl_expired,   got.ttl_expired);
      field_check("next_ttl",      want.next_ttl,      got.next_ttl);
      field_check("next_flags",    want.next_flags,    got.next_flags);
      field_check("priority_res",  want.prio,          got.prio);
      field_check("ctrl_count",    want.ctrl_count,    got.ctrl_count);
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [79:0]          s_tdata;
  logic                 s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [39:0]          m_tdata;

  dedup_scoreboard sb;
  logic [7:0]      cfg_plan [8];
  hdr_t            sent_log[$];
  int              send_idle;
  int              recv_idle;
  int              cycle_count;

  mesh_frame_dedup_router #(.WINDOW(WINDOW)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (s_tvalid && s_tready) sb.note_header(s_tdata[73:0], s_tuser);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("mesh_frame_dedup_router: mismatch");
    $finish;
  end

  function automatic hdr_t mk_hdr(logic complete, logic [7:0] mg, logic [7:0] src,
                                  logic [7:0] dst, logic [7:0] flags, logic [7:0] cls,
                                  logic [15:0] seq, logic [7:0] ttl, logic [7:0] fbyte,
                                  logic fpres);
    hdr_t h;
    h.header_complete = complete;
    h.magic_byte      = mg;
    h.source_node     = src;
    h.dest_node       = dst;
    h.flag_bits       = flags;
    h.class_code      = cls;
    h.frame_seq       = seq;
    h.hop_ttl         = ttl;
    h.frag_byte       = fbyte;
    h.frag_present    = fpres;
    return h;
  endfunction

  // valid stays high from one word to the next unless a gap is drawn
  task automatic send_word(hdr_t h, logic cmd);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, h};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // a write to an unused index goes first; it must leave everything alone
  task automatic apply_config();
    int idx;
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'($urandom_range(15, int'(REG_VIDEO_CLASS) + 1));
    cfg_data  <= 8'($urandom);
    do @(posedge clk); while (!cfg_ready);
    for (idx = REG_RELAY_ENABLE; idx <= REG_VIDEO_CLASS; idx++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(idx);
      cfg_data  <= cfg_plan[idx];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 8'h00;
    if (r < 30) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic plan_config(int ph);
    int idx;
    for (idx = REG_RELAY_ENABLE; idx <= REG_VIDEO_CLASS; idx++)
      cfg_plan[idx] = (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : pick_byte();
    // upper data bits of the enable are don't-care
    cfg_plan[REG_RELAY_ENABLE] = {7'($urandom), (ph < 2) || ($urandom_range(3) != 0)};
    if (ph == 2) cfg_plan[REG_RELAY_ENABLE][0] = 1'b0;
    if ($urandom_range(4) == 0) cfg_plan[REG_TELEM_CLASS] = cfg_plan[REG_CTRL_CLASS];
    if ($urandom_range(4) == 0) cfg_plan[REG_VIDEO_CLASS] = cfg_plan[REG_TELEM_CLASS];
  endtask

  // mostly well-formed headers, with old keys replayed to hit the history
  task automatic random_word();
    hdr_t        h;
    hdr_t        old;
    logic [95:0] raw;
    int          r;
    raw = {$urandom, $urandom, $urandom};
    h   = raw[73:0];
    r   = $urandom_range(99);
    if (r < 5) begin
      send_word(h, CMD_NEW_SLOT);
    end else if (r < 15) begin
      send_word(h, CMD_HEADER);
    end else if (r < 20) begin
      h.header_complete = 1'b1;
      h.magic_byte = cfg_plan[REG_FRAME_MAGIC];
      if ($urandom_range(1)) h.header_complete = 1'b0;
      else h.magic_byte = ~h.magic_byte;
      send_word(h, CMD_HEADER);
    end else begin
      h.header_complete = 1'b1;
      h.magic_byte = cfg_plan[REG_FRAME_MAGIC];
      case ($urandom_range(3))
        0: h.source_node = cfg_plan[REG_OWN_NODE];
        1: h.source_node = BROADCAST_NODE;
        default: ;
      endcase
      case ($urandom_range(3))
        0: h.dest_node = cfg_plan[REG_OWN_NODE];
        1: h.dest_node = BROADCAST_NODE;
        default: ;
      endcase
      case ($urandom_range(3))
        0: h.class_code = cfg_plan[REG_CTRL_CLASS];
        1: h.class_code = cfg_plan[REG_TELEM_CLASS];
        2: h.class_code = cfg_plan[REG_VIDEO_CLASS];
        default: ;
      endcase
      case ($urandom_range(5))
        0: h.hop_ttl = 8'd0;
        1: h.hop_ttl = 8'd1;
        2: h.hop_ttl = 8'd2;
        default: ;
      endcase
      if (sent_log.size() != 0 && $urandom_range(99) < 35) begin
        old = sent_log[$urandom_range(sent_log.size() - 1)];
        h.source_node  = old.source_node;
        h.frame_seq    = old.frame_seq;
        h.flag_bits    = old.flag_bits;
        h.frag_byte    = old.frag_byte;
        h.frag_present = old.frag_present;
      end
      sent_log.push_back(h);
      if (sent_log.size() > 2 * WINDOW) void'(sent_log.pop_front());
      send_word(h, CMD_HEADER);
    end
  endtask

  initial begin
    int ph;
    int n;
    sb = new();
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= CMD_HEADER;
    send_idle = 9;
    recv_idle = 55;
    cfg_plan = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // defaults after reset: relay off, magic 0, control class 0
    send_word(mk_hdr(1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 1),
              CMD_NEW_SLOT);
    send_word(mk_hdr(0, 8'h00, 8'h01, 8'h02, 8'h00, 8'h00, 16'h0001, 8'h05, 8'h00, 0),
              CMD_HEADER);
    send_word(mk_hdr(1, 8'hA5, 8'h01, 8'h02, 8'h00, 8'h00, 16'h0001, 8'h05, 8'h00, 0),
              CMD_HEADER);
    send_word(mk_hdr(1, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00, 16'h1234, 8'h08, 8'h00, 0),
              CMD_HEADER);
    send_word(mk_hdr(1, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00, 16'h1234, 8'h08, 8'h00, 0),
              CMD_HEADER);
    send_word(mk_hdr(1, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 1),
              CMD_HEADER);
    drain();

    cfg_plan = '{8'h01, 8'h42, 8'hC3, 8'h80, 8'h01, 8'h10, 8'h20, 8'h30};
    apply_config();
    send_word(mk_hdr(1, 8'hC3, 8'h11, 8'h42, 8'h00, 8'h10, 16'h0001, 8'h05, 8'h00, 0),
              CMD_HEADER);
    send_word(mk_hdr(1, 8'hC3, 8'h11, 8'hFF, 8'h00, 8'h20, 16'h0002, 8'h05, 8'h00, 0),
              CMD_HEADER);
    send_word(mk_hdr(1, 8'hC3, 8'h11, 8'h07, 8'h00, 8'h30, 16'h0003, 8'h01, 8'h00, 0),
              CMD_HEADER);
    send_word(mk_hdr(1, 8'hC3, 8'h11, 8'h07, 8'h00, 8'h30, 16'h0004, 8'h00, 8'h00, 0),
              CMD_HEADER);
    send_word(mk_hdr(1, 8'hC3, 8'h11, 8'h07, 8'h00, 8'h30, 16'h0005, 8'h02, 8'h00, 0),
              CMD_HEADER);
    send_word(mk_hdr(1, 8'hC3, 8'h11, 8'h07, 8'hFF, 8'h44, 16'h0006, 8'hFF, 8'h00, 0),
              CMD_HEADER);
    // sent by this node: never relayed, and not for us either
    send_word(mk_hdr(1, 8'hC3, 8'h42, 8'h07, 8'h00, 8'h10, 16'h0007, 8'h09, 8'h00, 0),
              CMD_HEADER);
    // fragments: a missing index byte reads as index 0
    send_word(mk_hdr(1, 8'hC3, 8'h22, 8'h07, 8'h80, 8'h10, 16'h0100, 8'h09, 8'h07, 1),
              CMD_HEADER);
    send_word(mk_hdr(1, 8'hC3, 8'h22, 8'h07, 8'h80, 8'h10, 16'h0100, 8'h09, 8'h09, 0),
              CMD_HEADER);
    send_word(mk_hdr(1, 8'hC3, 8'h22, 8'h07, 8'h80, 8'h10, 16'h0100, 8'h09, 8'h00, 1),
              CMD_HEADER);
    send_word(mk_hdr(1, 8'hC3, 8'h22, 8'h07, 8'h00, 8'h10, 16'h0100, 8'h09, 8'h07, 1),
              CMD_HEADER);
    send_word(mk_hdr(1, 8'hC3, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 0),
              CMD_NEW_SLOT);
    send_word(mk_hdr(1, 8'hC3, 8'h33, 8'hFF, 8'h00, 8'h10, 16'h0200, 8'h03, 8'h00, 0),
              CMD_HEADER);
    drain();

    // own node equal to broadcast, all class codes the same
    cfg_plan = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h55, 8'h55, 8'h55};
    apply_config();
    send_word(mk_hdr(1, 8'hFF, 8'h01, 8'hFF, 8'h00, 8'h55, 16'h0000, 8'h02, 8'h00, 0),
              CMD_HEADER);
    send_word(mk_hdr(1, 8'hFF, 8'hFF, 8'h03, 8'h00, 8'h55, 16'h0001, 8'h09, 8'h00, 0),
              CMD_HEADER);
    drain();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 3) begin
        send_idle = 9;
        recv_idle = 55;
      end else if (ph < 6) begin
        send_idle = 55;
        recv_idle = 9;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      plan_config(ph);
      apply_config();
      for (n = 0; n < WORDS_PER_PHASE; n++) random_word();
      drain();
    end

    repeat (WINDOW + 3) @(posedge clk);
    if (sb.pending.size() != 0) sb.errors++;
    if (sb.errors == 0)
      $display("mesh_frame_dedup_router: match");
    else
      $display("mesh_frame_dedup_router: mismatch");
    $finish;
  end

endmodule

// ===== mesh_frame_dedup_router.f =====
sv/mfdr_pkg.sv
sv/mfdr_cell.sv
sv/mesh_frame_dedup_router.sv
tb/tb_mesh_frame_dedup_router.sv
